### rtl/pps_pkg.sv
// Package for the preemptive priority scheduler: widths, defaults, constants and FSM type.
`default_nettype none
package pps_pkg;

    // Payload field widths
    localparam int MODE_W     = 1;
    localparam int SLOT_W     = 4;
    localparam int TIME_IO_W  = 16;
    localparam int PRIO_W     = 8;

    // Parameter defaults
    localparam int DEF_MAX_PROCESSES = 16;
    localparam int DEF_TIME_WIDTH    = 16;

    // Best-priority seed; above any real priority so the first eligible slot wins
    localparam int          PICK_PRIO_W      = 10;
    localparam logic [9:0]  NO_PICK_PRIORITY = 10'd999;

    // Item kinds
    localparam logic [MODE_W-1:0] MODE_LOAD = 1'b0;
    localparam logic [MODE_W-1:0] MODE_TICK = 1'b1;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_FINISH
    } t_state;

endpackage
`default_nettype wire

### rtl/pps_if.sv
// Valid/ready channel interfaces for scheduler requests and tick results.
`default_nettype none
interface pps_req_if;
    logic                          valid;
    logic                          ready;
    logic [pps_pkg::MODE_W-1:0]    mode;
    logic [pps_pkg::SLOT_W-1:0]    slot;
    logic [pps_pkg::TIME_IO_W-1:0] arrival_time;
    logic [pps_pkg::TIME_IO_W-1:0] burst_time;
    logic [pps_pkg::PRIO_W-1:0]    priority_req;

    modport source (output valid, mode, slot, arrival_time, burst_time, priority_req,
                    input ready);
    modport sink   (input valid, mode, slot, arrival_time, burst_time, priority_req,
                    output ready);
endinterface

interface pps_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [pps_pkg::TIME_IO_W-1:0] tick_time;
    logic                          idle;
    logic [pps_pkg::SLOT_W-1:0]    running_slot;
    logic                          finished;
    logic [pps_pkg::TIME_IO_W-1:0] turnaround;
    logic [pps_pkg::TIME_IO_W-1:0] waiting;
    logic                          all_done;

    modport source (output valid, tick_time, idle, running_slot, finished, turnaround,
                    waiting, all_done, input ready);
    modport sink   (input valid, tick_time, idle, running_slot, finished, turnaround,
                    waiting, all_done, output ready);
endinterface
`default_nettype wire

### rtl/preemptive_priority_scheduler_top.sv
// Preemptive priority scheduler: slot table, scan sequencer and result register.
//
// Usage:
//   i_req carries load beats (mode 0: write one slot's arrival, burst and
//   priority, remaining work = burst) and tick beats (mode 1: run one time
//   unit). o_rsp carries one result beat per tick; loads produce none.
//   A load is taken in the idle state and loads can follow back to back.
//   A tick scans every slot, one per cycle, through a single compare unit,
//   then passes through the update state when a slot runs (not when idle)
//   and the finish state, which registers the result. Ready returns after
//   the finish state, and one item is worked on at a time.
//   The result sits in an output register, so the next item is accepted
//   while a result waits. If a tick finishes while that register is still
//   full, the block holds in its final step until the receiver takes it.
//   Reset clears the time to zero, marks every slot empty (no work left)
//   and drops any pending result. Arrival, burst and priority storage is
//   not cleared; an empty slot is never picked so it is never consulted.
//   Time saturates at its maximum value.
`default_nettype none
module preemptive_priority_scheduler_top #(
    parameter int MAX_PROCESSES = pps_pkg::DEF_MAX_PROCESSES,
    parameter int TIME_WIDTH    = pps_pkg::DEF_TIME_WIDTH
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pps_req_if.sink    i_req,
    pps_rsp_if.source  o_rsp
);

    localparam int SW = $clog2(MAX_PROCESSES);
    localparam logic [SW-1:0] LAST_IDX = SW'(MAX_PROCESSES - 1);
    localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};

    typedef logic [TIME_WIDTH-1:0]       t_time;
    typedef logic [pps_pkg::PRIO_W-1:0]  t_prio;

    // Slot table
    t_time r_arr [MAX_PROCESSES];
    t_time r_bur [MAX_PROCESSES];
    t_time r_rem [MAX_PROCESSES];
    t_prio r_pri [MAX_PROCESSES];
    logic [MAX_PROCESSES-1:0] r_busy;

    // Sequencer and scan state
    pps_pkg::t_state r_state, n_state;
    logic [SW-1:0]   r_idx;
    logic [SW-1:0]   r_pick;
    logic            r_found;
    logic [pps_pkg::PICK_PRIO_W-1:0] r_best_prio;
    t_time           r_time;
    logic            r_fin;
    t_time           r_tat;
    t_time           r_bur_sel;

    // Result register
    logic                           r_out_valid;
    logic [pps_pkg::TIME_IO_W-1:0]  r_o_tick_time;
    logic                           r_o_idle;
    logic [pps_pkg::SLOT_W-1:0]     r_o_running_slot;
    logic                           r_o_finished;
    logic [pps_pkg::TIME_IO_W-1:0]  r_o_turnaround;
    logic [pps_pkg::TIME_IO_W-1:0]  r_o_waiting;
    logic                           r_o_all_done;

    logic          in_acc;
    logic          load_we;
    logic          tick_go;
    logic          out_load;
    logic          slot_ok;
    logic [SW-1:0] load_idx;
    logic [SW-1:0] rd_idx;
    t_time         rd_arr;
    t_time         rd_bur;
    t_time         rd_rem;
    t_prio         rd_pri;
    logic          rd_busy;
    logic          scan_hit;
    t_time         rem_dec;
    t_time         done_at;
    t_time         tat_calc;
    t_time         wait_calc;

    // Single read port into the slot table
    assign rd_idx  = (r_state == pps_pkg::ST_SCAN) ? r_idx : r_pick;
    assign rd_arr  = r_arr[rd_idx];
    assign rd_bur  = r_bur[rd_idx];
    assign rd_rem  = r_rem[rd_idx];
    assign rd_pri  = r_pri[rd_idx];
    assign rd_busy = r_busy[rd_idx];

    // Shared compare: arrived, has work, strictly better priority
    assign scan_hit = rd_busy && (rd_arr <= r_time)
                      && ({2'b00, rd_pri} < r_best_prio);

    // Completion arithmetic
    assign rem_dec   = rd_rem - t_time'(1);
    assign done_at   = (r_time != TIME_MAX) ? r_time + t_time'(1) : r_time;
    assign tat_calc  = (done_at >= rd_arr) ? done_at - rd_arr : '0;
    assign wait_calc = (r_tat >= r_bur_sel) ? r_tat - r_bur_sel : '0;

    // Load decode
    assign load_idx = SW'(i_req.slot);
    assign slot_ok  = (32'(i_req.slot) < 32'(MAX_PROCESSES));

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pps_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and control
    always_comb begin
        n_state     = r_state;
        i_req.ready = 1'b0;
        out_load    = 1'b0;
        unique case (r_state)
            pps_pkg::ST_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid && (i_req.mode == pps_pkg::MODE_TICK)) begin
                    n_state = pps_pkg::ST_SCAN;
                end
            end
            pps_pkg::ST_SCAN: begin
                if (r_idx == LAST_IDX) begin
                    if (r_found || scan_hit) begin
                        n_state = pps_pkg::ST_UPDATE;
                    end else begin
                        n_state = pps_pkg::ST_FINISH;
                    end
                end
            end
            pps_pkg::ST_UPDATE: begin
                n_state = pps_pkg::ST_FINISH;
            end
            pps_pkg::ST_FINISH: begin
                out_load = !r_out_valid || o_rsp.ready;
                if (out_load) begin
                    n_state = pps_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pps_pkg::ST_IDLE;
            end
        endcase
    end

    assign in_acc  = i_req.valid && i_req.ready;
    assign load_we = in_acc && (i_req.mode == pps_pkg::MODE_LOAD) && slot_ok;
    assign tick_go = in_acc && (i_req.mode == pps_pkg::MODE_TICK);

    // Control state: busy flags, time, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= '0;
            r_time      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load_we) begin
                r_busy[load_idx] <= (t_time'(i_req.burst_time) != '0);
            end else if (r_state == pps_pkg::ST_UPDATE) begin
                r_busy[r_pick] <= (rem_dec != '0);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
                if (r_time != TIME_MAX) begin
                    r_time <= r_time + t_time'(1);
                end
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Slot table writes
    always_ff @(posedge i_clk) begin
        if (load_we) begin
            r_arr[load_idx] <= t_time'(i_req.arrival_time);
            r_bur[load_idx] <= t_time'(i_req.burst_time);
            r_rem[load_idx] <= t_time'(i_req.burst_time);
            r_pri[load_idx] <= i_req.priority_req;
        end else if (r_state == pps_pkg::ST_UPDATE) begin
            r_rem[r_pick] <= rem_dec;
        end
    end

    // Scan, update and result datapath
    always_ff @(posedge i_clk) begin
        if (tick_go) begin
            r_idx       <= '0;
            r_pick      <= '0;
            r_found     <= 1'b0;
            r_best_prio <= pps_pkg::NO_PICK_PRIORITY;
            r_fin       <= 1'b0;
            r_tat       <= '0;
            r_bur_sel   <= '0;
        end
        if (r_state == pps_pkg::ST_SCAN) begin
            r_idx <= r_idx + SW'(1);
            if (scan_hit) begin
                r_best_prio <= {2'b00, rd_pri};
                r_pick      <= r_idx;
                r_found     <= 1'b1;
            end
        end
        if (r_state == pps_pkg::ST_UPDATE) begin
            if (rem_dec == '0) begin
                r_fin     <= 1'b1;
                r_tat     <= tat_calc;
                r_bur_sel <= rd_bur;
            end
        end
        if (out_load) begin
            r_o_tick_time    <= pps_pkg::TIME_IO_W'(r_time);
            r_o_idle         <= !r_found;
            r_o_running_slot <= r_found ? pps_pkg::SLOT_W'(r_pick) : '0;
            r_o_finished     <= r_fin;
            r_o_turnaround   <= pps_pkg::TIME_IO_W'(r_tat);
            r_o_waiting      <= pps_pkg::TIME_IO_W'(wait_calc);
            r_o_all_done     <= ~|r_busy;
        end
    end

    // Result channel
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.tick_time    = r_o_tick_time;
    assign o_rsp.idle         = r_o_idle;
    assign o_rsp.running_slot = r_o_running_slot;
    assign o_rsp.finished     = r_o_finished;
    assign o_rsp.turnaround   = r_o_turnaround;
    assign o_rsp.waiting      = r_o_waiting;
    assign o_rsp.all_done     = r_o_all_done;

endmodule
`default_nettype wire

### tb/sv/preemptive_priority_scheduler_top_test.sv
// Testbench for the preemptive priority scheduler: directed and random loads and ticks.
`timescale 1ns / 1ps
`default_nettype none
module preemptive_priority_scheduler_top_test;

    localparam int MODE_W    = pps_pkg::MODE_W;
    localparam int SLOT_W    = pps_pkg::SLOT_W;
    localparam int TIME_IO_W = pps_pkg::TIME_IO_W;
    localparam int PRIO_W    = pps_pkg::PRIO_W;

    localparam int NUM_SLOTS = pps_pkg::DEF_MAX_PROCESSES;
    localparam logic [TIME_IO_W-1:0] TIME_MAX = '1;
    localparam int RANDOM_ITEMS = 1020;
    localparam int IDLE_LIMIT = 4000;

    // One tick result as the block reports it
    typedef struct packed {
        logic [TIME_IO_W-1:0] tick_time;
        logic                 idle;
        logic [SLOT_W-1:0]    running_slot;
        logic                 finished;
        logic [TIME_IO_W-1:0] turnaround;
        logic [TIME_IO_W-1:0] waiting;
        logic                 all_done;
    } t_tick_result;

    logic i_clk;
    logic i_rst_n;

    pps_req_if req_ch ();
    pps_rsp_if rsp_ch ();

    preemptive_priority_scheduler_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Predicted scheduler state
    logic [TIME_IO_W-1:0] slot_arrival   [NUM_SLOTS];
    logic [TIME_IO_W-1:0] slot_burst     [NUM_SLOTS];
    logic [TIME_IO_W-1:0] slot_remaining [NUM_SLOTS];
    logic [PRIO_W-1:0]    slot_prio      [NUM_SLOTS];
    logic [TIME_IO_W-1:0] sched_now;

    t_tick_result expected_ticks[$];

    int error_count = 0;
    int loads_sent = 0;
    int ticks_sent = 0;
    int completions_seen = 0;
    int idle_seen = 0;
    logic [TIME_IO_W-1:0] last_tick_time = '0;

    // Sender and receiver pacing
    int  sender_burst_left = 0;
    bit  ready_level = 1'b0;
    int  ready_run = 0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Write one slot of the predicted table
    function automatic void schedule_load(logic [SLOT_W-1:0] s, logic [TIME_IO_W-1:0] arr,
                                          logic [TIME_IO_W-1:0] burst, logic [PRIO_W-1:0] prio);
        slot_arrival[s]   = arr;
        slot_burst[s]     = burst;
        slot_prio[s]      = prio;
        slot_remaining[s] = burst;
    endfunction

    // Run one predicted tick: pick, decrement, report, advance time
    function automatic t_tick_result schedule_tick();
        t_tick_result r;
        int best_prio;
        int pick;
        logic [TIME_IO_W-1:0] done_at;
        logic [TIME_IO_W-1:0] tat;
        r = '0;
        best_prio = int'(pps_pkg::NO_PICK_PRIORITY);
        pick = -1;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (slot_remaining[i] != '0 && slot_arrival[i] <= sched_now &&
                int'(slot_prio[i]) < best_prio) begin
                best_prio = int'(slot_prio[i]);
                pick = i;
            end
        end
        r.tick_time = sched_now;
        if (pick < 0) begin
            r.idle = 1'b1;
        end else begin
            r.running_slot = SLOT_W'(pick);
            slot_remaining[pick] = slot_remaining[pick] - 1'b1;
            if (slot_remaining[pick] == '0) begin
                done_at = (sched_now < TIME_MAX) ? sched_now + 1'b1 : TIME_MAX;
                tat = (done_at >= slot_arrival[pick]) ? done_at - slot_arrival[pick] : '0;
                r.finished   = 1'b1;
                r.turnaround = tat;
                r.waiting    = (tat >= slot_burst[pick]) ? tat - slot_burst[pick] : '0;
            end
        end
        r.all_done = 1'b1;
        for (int i = 0; i < NUM_SLOTS; i++)
            if (slot_remaining[i] != '0) r.all_done = 1'b0;
        if (sched_now < TIME_MAX) sched_now = sched_now + 1'b1;
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            error_count++;
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        end
    endfunction

    // Send one beat with bursty pacing; updates the prediction on acceptance
    task automatic send_beat(logic [MODE_W-1:0] mode, logic [SLOT_W-1:0] s,
                             logic [TIME_IO_W-1:0] arr, logic [TIME_IO_W-1:0] burst,
                             logic [PRIO_W-1:0] prio);
        int gap;
        if (sender_burst_left == 0) begin
            gap = ($urandom_range(0, 4) == 0) ? 0 :
                  $urandom_range(1, ($urandom_range(0, 3) == 0) ? 45 : 8);
            sender_burst_left = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 60 : 10);
            if (gap > 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        req_ch.valid        <= 1'b1;
        req_ch.mode         <= mode;
        req_ch.slot         <= s;
        req_ch.arrival_time <= arr;
        req_ch.burst_time   <= burst;
        req_ch.priority_req <= prio;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        if (mode == pps_pkg::MODE_TICK) begin
            expected_ticks.push_back(schedule_tick());
            ticks_sent++;
        end else begin
            schedule_load(s, arr, burst, prio);
            loads_sent++;
        end
        if (sender_burst_left > 0) sender_burst_left--;
    endtask

    task automatic send_load(logic [SLOT_W-1:0] s, logic [TIME_IO_W-1:0] arr,
                             logic [TIME_IO_W-1:0] burst, logic [PRIO_W-1:0] prio);
        send_beat(pps_pkg::MODE_LOAD, s, arr, burst, prio);
    endtask

    task automatic send_tick();
        send_beat(pps_pkg::MODE_TICK, SLOT_W'($urandom), TIME_IO_W'($urandom),
                  TIME_IO_W'($urandom), PRIO_W'($urandom));
    endtask

    // Hold the sender off until every predicted result has come back
    task automatic wait_for_drain();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_ticks.size() != 0) @(posedge i_clk);
    endtask

    // Cancel slots holding more work than a threshold by reloading with zero burst
    task automatic cancel_long_work(int threshold);
        for (int s = 0; s < NUM_SLOTS; s++)
            if (int'(slot_remaining[s]) > threshold)
                send_load(SLOT_W'(s), TIME_IO_W'($urandom), '0, PRIO_W'($urandom));
    endtask

    function automatic logic [TIME_IO_W-1:0] time_after(int delta);
        int t;
        t = int'(sched_now) + delta;
        return (t > int'(TIME_MAX)) ? TIME_MAX : TIME_IO_W'(t);
    endfunction

    // Ticks on an empty table are idle
    task automatic test_idle_after_reset();
        send_tick();
        send_tick();
    endtask

    // Field extremes, zero burst, priority ties, future arrival and reload
    task automatic test_extremes_and_ties();
        send_load(4'd15, '0, '0, '0);
        send_load(4'd9, '0, 16'd2, 8'd255);
        send_load(4'd2, '0, 16'd1, 8'd255);
        send_load(4'd0, TIME_MAX, TIME_MAX, 8'd0);
        send_tick();
        send_tick();
        send_load(4'd9, sched_now, 16'd2, 8'd255);
        send_tick();
        send_tick();
        send_load(4'd0, '0, '0, 8'd0);
        send_tick();
    endtask

    // A later, more urgent arrival preempts; a reload restarts the work
    task automatic test_preemption();
        send_load(4'd4, sched_now, 16'd3, 8'd100);
        send_tick();
        send_load(4'd7, time_after(1), 16'd1, 8'd10);
        send_tick();
        send_tick();
        send_load(4'd4, sched_now, 16'd2, 8'd100);
        send_tick();
        send_tick();
    endtask

    // Random workloads: load a few slots, tick them through, with noise mixed in
    task automatic test_random_workloads();
        int start_items;
        int nslots;
        int work;
        bit tie_prio;
        logic [TIME_IO_W-1:0] burst;
        start_items = loads_sent + ticks_sent;
        while (loads_sent + ticks_sent - start_items < RANDOM_ITEMS) begin
            nslots = $urandom_range(1, 5);
            tie_prio = ($urandom_range(0, 2) == 0);
            work = 0;
            for (int n = 0; n < nslots; n++) begin
                burst = ($urandom_range(0, 7) == 0) ? '0 : TIME_IO_W'($urandom_range(1, 6));
                work += int'(burst);
                send_load(SLOT_W'($urandom), time_after($urandom_range(0, 12)), burst,
                          tie_prio ? PRIO_W'($urandom_range(0, 2)) : PRIO_W'($urandom));
            end
            // noise: any field value at all
            if ($urandom_range(0, 4) == 0)
                send_load(SLOT_W'($urandom), TIME_IO_W'($urandom), TIME_IO_W'($urandom),
                          PRIO_W'($urandom));
            work += $urandom_range(0, 4);
            for (int k = 0; k < work; k++) begin
                if ($urandom_range(0, 5) == 0) begin
                    burst = TIME_IO_W'($urandom_range(1, 4));
                    work += int'(burst);
                    send_load(SLOT_W'($urandom), time_after($urandom_range(0, 3)), burst,
                              PRIO_W'($urandom));
                end
                send_tick();
            end
            cancel_long_work(40);
            if ($urandom_range(0, 7) == 0) wait_for_drain();
        end
    endtask

    // Result check and receiver stall pattern
    initial begin
        t_tick_result got;
        t_tick_result want;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
                got.tick_time    = rsp_ch.tick_time;
                got.idle         = rsp_ch.idle;
                got.running_slot = rsp_ch.running_slot;
                got.finished     = rsp_ch.finished;
                got.turnaround   = rsp_ch.turnaround;
                got.waiting      = rsp_ch.waiting;
                got.all_done     = rsp_ch.all_done;
                if (expected_ticks.size() == 0) begin
                    error_count++;
                    $error("result beat with no tick outstanding, tick_time %0d", got.tick_time);
                end else begin
                    want = expected_ticks.pop_front();
                    check_field("tick_time", want.tick_time, got.tick_time);
                    check_field("idle", want.idle, got.idle);
                    check_field("running_slot", want.running_slot, got.running_slot);
                    check_field("finished", want.finished, got.finished);
                    check_field("turnaround", want.turnaround, got.turnaround);
                    check_field("waiting", want.waiting, got.waiting);
                    check_field("all_done", want.all_done, got.all_done);
                end
                completions_seen += got.finished;
                idle_seen += got.idle;
                last_tick_time = got.tick_time;
            end
            if (ready_run == 0) begin
                ready_level = !ready_level;
                if (ready_level)
                    ready_run = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 150 : 20);
                else
                    ready_run = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 60 : 6);
            end
            ready_run--;
            rsp_ch.ready <= ready_level;
        end
    end

    // Watchdog on cycles with no beat on either channel
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || !i_rst_n)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Main sequence
    initial begin
        for (int s = 0; s < NUM_SLOTS; s++) schedule_load(SLOT_W'(s), '0, '0, '0);
        sched_now = '0;
        i_rst_n             <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.mode         <= pps_pkg::MODE_LOAD;
        req_ch.slot         <= '0;
        req_ch.arrival_time <= '0;
        req_ch.burst_time   <= '0;
        req_ch.priority_req <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_after_reset();
        test_extremes_and_ties();
        test_preemption();
        wait_for_drain();
        test_random_workloads();

        req_ch.valid <= 1'b0;
        while (expected_ticks.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("Run covered %0d loads and %0d ticks: %0d completions, %0d idle ticks.",
                 loads_sent, ticks_sent, completions_seen, idle_seen);
        $display("Scheduler time ran up to %0d with ties, preemption and reloads mixed in.",
                 last_tick_time);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
`default_nettype wire
